FILE: src/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg
// Shared types and constants of the sorted insert table: field widths,
// status and mode codes, sequencer states and the result record.
// ----------------------------------------------------------------------------
package sit_pkg;

    // fixed field widths of the stream payload
    localparam int KEY_W    = 32;
    localparam int PAY_W    = 16;
    localparam int POS_W    = 7;
    localparam int SLOT_W   = 7;
    localparam int FILL_W   = 8;
    localparam int STATUS_W = 2;

    // item kinds carried in s_tuser
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    // result status codes carried in m_tuser
    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_POS = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_REQ,
        ST_RD_DATA,
        ST_INS_REQ,
        ST_INS_CMP,
        ST_INS_WRITE,
        ST_DONE
    } state_t;

    // one finished result
    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [SLOT_W-1:0]       slot;
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        payload;
        logic [FILL_W-1:0]       fill;
    } result_t;

endpackage

FILE: src/sit_ram.sv
// ----------------------------------------------------------------------------
// sit_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module sit_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 128,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/sit_seq.sv
// ----------------------------------------------------------------------------
// sit_seq
// Sequencer and datapath of the sorted insert table. An insert walks down
// from the top of the table through one shared signed key comparator,
// moving each larger entry up one place until the gap for the new record
// is found. A read fetches one entry.
// ----------------------------------------------------------------------------
module sit_seq
    import sit_pkg::*;
#(
    parameter int DEPTH        = 128,
    parameter int PAYLOAD_BITS = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int WORD_W = KEY_W + PAYLOAD_BITS
) (
    input  logic              aclk,
    input  logic              aresetn,
    // item side
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_mode,
    input  logic [KEY_W-1:0]  in_key,
    input  logic [PAY_W-1:0]  in_payload,
    input  logic [POS_W-1:0]  in_position,
    // result side
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res,
    // table memory
    output logic              ram_wr_en,
    output logic [ADDR_W-1:0] ram_wr_addr,
    output logic [WORD_W-1:0] ram_wr_data,
    output logic              ram_rd_en,
    output logic [ADDR_W-1:0] ram_rd_addr,
    input  logic [WORD_W-1:0] ram_rd_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]        count_reg;
    logic [ADDR_W-1:0]       j_reg;
    logic [KEY_W-1:0]        key_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic [POS_W-1:0]        pos_reg;
    result_t                 res_reg;

    logic              in_fire;
    logic              pos_ge_count;
    logic              table_full;
    logic              key_less;
    logic              j_above_one;
    logic [KEY_W-1:0]  rd_key;
    logic [CNT_W-1:0]  count_inc;

    assign in_fire      = in_valid && in_ready;
    assign pos_ge_count = CMP_W'(in_position) >= CMP_W'(count_reg);
    assign table_full   = count_reg == CNT_W'(DEPTH);
    assign count_inc    = count_reg + CNT_W'(1);
    assign j_above_one  = j_reg > ADDR_W'(1);
    assign rd_key       = ram_rd_data[WORD_W-1 -: KEY_W];

    // shared compare unit: new key strictly below the stored key
    assign key_less = $signed(key_reg) < $signed(rd_key);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    if (in_mode == MODE_READ) begin
                        state_next = pos_ge_count ? ST_DONE : ST_RD_REQ;
                    end else if (table_full) begin
                        state_next = ST_DONE;
                    end else if (count_reg == '0) begin
                        state_next = ST_INS_WRITE;
                    end else begin
                        state_next = ST_INS_REQ;
                    end
                end
            end
            ST_RD_REQ:    state_next = ST_RD_DATA;
            ST_RD_DATA:   state_next = ST_DONE;
            ST_INS_REQ:   state_next = ST_INS_CMP;
            ST_INS_CMP: begin
                if (!(key_less && j_above_one)) begin
                    state_next = ST_INS_WRITE;
                end
            end
            ST_INS_WRITE: state_next = ST_DONE;
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs and memory controls
    always_comb begin
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = j_reg;
        ram_wr_data = {key_reg, pay_reg};
        ram_rd_en   = 1'b0;
        ram_rd_addr = j_reg - ADDR_W'(1);
        case (state_reg)
            ST_IDLE: begin
                // no transfer while reset is held
                in_ready = aresetn;
            end
            ST_RD_REQ: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = ADDR_W'(pos_reg);
            end
            ST_INS_REQ: begin
                ram_rd_en = 1'b1;
            end
            ST_INS_CMP: begin
                // move the larger entry up and fetch the one below it
                if (key_less) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_data = ram_rd_data;
                    ram_rd_en   = j_above_one;
                    ram_rd_addr = j_reg - ADDR_W'(2);
                end
            end
            ST_INS_WRITE: begin
                ram_wr_en = 1'b1;
            end
            ST_DONE: begin
                res_valid = 1'b1;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign res = res_reg;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_INS_WRITE) begin
                count_reg <= count_inc;
            end
        end
    end

    // item and result registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            key_reg <= in_key;
            pay_reg <= PAYLOAD_BITS'(in_payload);
            pos_reg <= in_position;
            j_reg   <= ADDR_W'(count_reg);
            if (in_mode == MODE_READ) begin
                res_reg.status  <= STATUS_BAD_POS;
                res_reg.slot    <= SLOT_W'(in_position);
                res_reg.key     <= '0;
                res_reg.payload <= '0;
            end else begin
                res_reg.status  <= STATUS_FULL;
                res_reg.slot    <= '0;
                res_reg.key     <= in_key;
                res_reg.payload <= PAY_W'(PAYLOAD_BITS'(in_payload));
            end
            res_reg.fill <= FILL_W'(count_reg);
        end
        if (state_reg == ST_RD_DATA) begin
            res_reg.status  <= STATUS_OK;
            res_reg.key     <= rd_key;
            res_reg.payload <= PAY_W'(ram_rd_data[PAYLOAD_BITS-1:0]);
        end
        if (state_reg == ST_INS_CMP && key_less) begin
            j_reg <= j_reg - ADDR_W'(1);
        end
        if (state_reg == ST_INS_WRITE) begin
            res_reg.status  <= STATUS_OK;
            res_reg.slot    <= SLOT_W'(j_reg);
            res_reg.key     <= key_reg;
            res_reg.payload <= PAY_W'(pay_reg);
            res_reg.fill    <= FILL_W'(count_inc);
        end
    end

    // the record count never passes the table depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("record count above depth");

    // the walk never compares below the bottom entry
    a_walk_above_bottom: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_INS_CMP |-> j_reg != '0)
        else $error("insert walk below entry zero");

    // the count grows by one after each stored record
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_INS_WRITE |=> count_reg == $past(count_inc))
        else $error("count not advanced on insert");

    // the count holds outside the store step
    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_INS_WRITE |=> $stable(count_reg))
        else $error("count changed without insert");

    // an insert only starts walking into a table that has room
    a_walk_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_INS_REQ |-> !table_full)
        else $error("insert walk on a full table");

endmodule

FILE: src/sorted_insert_table_core.sv
// ----------------------------------------------------------------------------
// sorted_insert_table_core
// Bounded table of (key, payload) records kept in ascending signed key
// order, with an insert and a read operation and one result per item.
//
// channel  dir  tdata (low bit up)                         tuser
// s_       in   key[31:0] payload[47:32] position[54:48]    mode (0 ins, 1 rd)
// m_       out  slot[6:0] key_out[38:7] payload_out[54:39]  status[1:0]
//                fill[62:55]
//
// a read goes through the read request and read data states to its result;
// a rejected item goes straight to its result; an insert moves each larger
// record up (at most DEPTH - 1 of them) before it writes the new record, and
// writes at once into an empty table; one entry moves per cycle through the
// table ram's single read port and the shared key comparator
// s_tready is high only while the sequencer is idle and out of reset
// the output register lets the next item start while a result waits
// reset is synchronous, active low, and empties the table at once
// ----------------------------------------------------------------------------
module sorted_insert_table_core
    import sit_pkg::*;
#(
    parameter int DEPTH        = 128,
    parameter int PAYLOAD_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // item stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // key, payload, position, zero fill
    input  logic        s_tuser,   // mode
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // slot, key_out, payload_out, fill, zero fill
    output logic [1:0]  m_tuser    // status
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WORD_W = KEY_W + PAYLOAD_BITS;

    logic              res_valid;
    logic              res_ready;
    result_t           res;
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [WORD_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [WORD_W-1:0] ram_rd_data;

    logic    m_tvalid_reg;
    result_t m_res_reg;

    // sequencer
    sit_seq #(
        .DEPTH        (DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_mode     (s_tuser),
        .in_key      (s_tdata[31:0]),
        .in_payload  (s_tdata[47:32]),
        .in_position (s_tdata[54:48]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    // record store: key above payload
    sit_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // output register, loads when empty or drained in the same cycle
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    // result packing
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {1'b0, m_res_reg.fill, m_res_reg.payload,
                       m_res_reg.key, m_res_reg.slot};

endmodule
